[src/hsv_to_rgb_converter_macros.svh]
// Assertion macros used by the HSV to RGB converter top level.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define H2R_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define H2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hsv2rgb_pkg.sv]
// Types, constants and widths shared by the HSV to RGB converter modules.
package hsv2rgb_pkg;

    // Channel and hue widths.
    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 15;

    // Full scale of a channel.
    localparam longint unsigned CH_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;

    // One sector of the hue circle is 60 degrees, 3840 in 1/64 degree units.
    // It is 15 times 256; the doubling for rounding adds one more power of two.
    localparam int SPAN       = 3840;
    localparam int SPAN_BITS  = 12;
    localparam int SPAN_ODD   = 15;
    localparam int SPAN_SHIFT = 9;

    // Hue codes reach sector eight at most.
    localparam int MAX_SECTOR  = ((1 << HUE_BITS) - 1) / SPAN;
    localparam int SECTOR_BITS = $clog2(MAX_SECTOR + 1);

    // Denominator of q and t, and the width of their numerators.
    localparam int DEN_BITS = CHANNEL_BITS + SPAN_BITS;
    localparam longint unsigned DEN = SPAN * CH_MAX;
    localparam int NUM_BITS = CHANNEL_BITS + DEN_BITS;

    // Divisor of q and t after the power of two has been shifted off.
    localparam longint unsigned QT_DIV = SPAN_ODD * CH_MAX;
    localparam int QT_BITS = CHANNEL_BITS + 4;

    // Reciprocal division: shifted dividend widths and reciprocals.
    localparam int YQ_BITS = NUM_BITS + 1 - SPAN_SHIFT;
    localparam int YP_BITS = 2 * CHANNEL_BITS;
    localparam int QE_BITS = CHANNEL_BITS + 1;
    localparam longint unsigned RQ = (64'd1 << YQ_BITS) / QT_DIV;
    localparam longint unsigned RP = (64'd1 << YP_BITS) / CH_MAX;

    // Pipeline depth, from the hue decode register to the output register.
    localparam int NUM_STAGES = 6;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_BITS = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [SECTOR_BITS-1:0]  sector_t;
    typedef logic [SPAN_BITS-1:0]    span_t;

    // Sectors named after the colour at which they start.
    localparam sector_t SEC_RED    = sector_t'(0);
    localparam sector_t SEC_YELLOW = sector_t'(1);
    localparam sector_t SEC_GREEN  = sector_t'(2);
    localparam sector_t SEC_CYAN   = sector_t'(3);
    localparam sector_t SEC_BLUE   = sector_t'(4);

    // Decoded pixel after the first stage.
    typedef struct packed {
        sector_t sector;
        span_t   fr;
        span_t   frc;
        chan_t   sat;
        chan_t   sat_c;
        chan_t   val;
    } dec_t;

    // Numerators of p, q and t.
    typedef struct packed {
        sector_t             sector;
        chan_t               val;
        logic [YP_BITS-1:0]  pn;
        logic [NUM_BITS-1:0] qn;
        logic [NUM_BITS-1:0] tn;
    } prod_t;

    // Rounded and saturated p, q and t.
    typedef struct packed {
        sector_t sector;
        chan_t   val;
        chan_t   p;
        chan_t   q;
        chan_t   t;
    } quot_t;

    // Load enables of the two product stages.
    typedef struct packed {
        logic s2;
        logic s3;
    } mul_en_t;

    // Load enables of the two divider stages.
    typedef struct packed {
        logic s4;
        logic s5;
    } div_en_t;

endpackage

[src/hsv2rgb_hue_decode.sv]
// First pipeline stage: splits hue into sector and fraction, forms the complements.
module hsv2rgb_hue_decode (
    input  logic                              clk,
    input  logic                              en,
    input  logic [hsv2rgb_pkg::HUE_BITS-1:0]  hue,
    input  hsv2rgb_pkg::chan_t                saturation,
    input  hsv2rgb_pkg::chan_t                brightness,
    output hsv2rgb_pkg::dec_t                 dec
);
    import hsv2rgb_pkg::*;

    dec_t dec_reg;
    dec_t dec_next;

    // Sector by parallel compares against the sector boundaries.
    always_comb
    begin
        logic [HUE_BITS-1:0] base;
        sector_t             sector;
        logic [HUE_BITS-1:0] rest;
        base   = '0;
        sector = '0;
        for (int k = 1; k <= MAX_SECTOR; k++)
        begin
            if (hue >= HUE_BITS'(k * SPAN))
            begin
                sector = SECTOR_BITS'(k);
                base   = HUE_BITS'(k * SPAN);
            end
        end
        rest            = hue - base;
        dec_next.sector = sector;
        dec_next.fr     = rest[SPAN_BITS-1:0];
        dec_next.frc    = SPAN_BITS'(SPAN) - rest[SPAN_BITS-1:0];
        dec_next.sat    = saturation;
        dec_next.sat_c  = chan_t'(CH_MAX) - saturation;
        dec_next.val    = brightness;
    end

    // Stage register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule

[src/hsv2rgb_mul.sv]
// Second and third pipeline stages: products and numerators of p, q and t.
module hsv2rgb_mul (
    input  logic                 clk,
    input  hsv2rgb_pkg::mul_en_t en,
    input  hsv2rgb_pkg::dec_t    dec,
    output hsv2rgb_pkg::prod_t   prod
);
    import hsv2rgb_pkg::*;

    typedef struct packed {
        sector_t             sector;
        chan_t               val;
        logic [DEN_BITS-1:0] sfr;
        logic [DEN_BITS-1:0] sfrc;
        logic [YP_BITS-1:0]  pn;
    } part_t;

    part_t part_reg;
    part_t part_next;
    prod_t prod_reg;
    prod_t prod_next;

    // Saturation times fraction and its complement, value times (1 - s).
    always_comb
    begin
        part_next.sector = dec.sector;
        part_next.val    = dec.val;
        part_next.sfr    = DEN_BITS'(dec.sat) * DEN_BITS'(dec.fr);
        part_next.sfrc   = DEN_BITS'(dec.sat) * DEN_BITS'(dec.frc);
        part_next.pn     = YP_BITS'(dec.val) * YP_BITS'(dec.sat_c);
    end

    // Value times the remaining part of the full-scale denominator.
    always_comb
    begin
        logic [DEN_BITS-1:0] dq;
        logic [DEN_BITS-1:0] dt;
        dq               = DEN_BITS'(DEN) - part_reg.sfr;
        dt               = DEN_BITS'(DEN) - part_reg.sfrc;
        prod_next.sector = part_reg.sector;
        prod_next.val    = part_reg.val;
        prod_next.pn     = part_reg.pn;
        prod_next.qn     = NUM_BITS'(part_reg.val) * NUM_BITS'(dq);
        prod_next.tn     = NUM_BITS'(part_reg.val) * NUM_BITS'(dt);
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            part_reg <= part_next;
        end
        if (en.s3)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[src/hsv2rgb_cdiv.sv]
// Fourth and fifth pipeline stages: rounded division by constants through reciprocals.
module hsv2rgb_cdiv (
    input  logic                 clk,
    input  hsv2rgb_pkg::div_en_t en,
    input  hsv2rgb_pkg::prod_t   prod,
    output hsv2rgb_pkg::quot_t   quot
);
    import hsv2rgb_pkg::*;

    localparam int HI_BITS = QE_BITS + 1 + QT_BITS;
    localparam int MQ_BITS = YQ_BITS + QE_BITS;
    localparam int MP_BITS = YP_BITS + QE_BITS;

    typedef struct packed {
        sector_t            sector;
        chan_t              val;
        logic [YP_BITS-1:0] yp;
        logic [YQ_BITS-1:0] yq;
        logic [YQ_BITS-1:0] yt;
        logic [QE_BITS-1:0] pe;
        logic [QE_BITS-1:0] qe;
        logic [QE_BITS-1:0] te;
    } est_t;

    est_t  est_reg;
    est_t  est_next;
    quot_t quot_reg;
    quot_t quot_next;

    // The estimate is the quotient or one below it; one compare settles it.
    function automatic chan_t fix_quot(input logic [YQ_BITS-1:0] y,
                                       input logic [QE_BITS-1:0] e,
                                       input logic [QT_BITS-1:0] div);
        logic [QE_BITS:0]   e_inc;
        logic [HI_BITS-1:0] hi;
        logic [QE_BITS:0]   q;
        e_inc = {1'b0, e} + (QE_BITS+1)'(1);
        hi    = HI_BITS'(e_inc) * HI_BITS'(div);
        q     = (HI_BITS'(y) >= hi) ? e_inc : {1'b0, e};
        if (q > (QE_BITS+1)'(CH_MAX))
        begin
            return chan_t'(CH_MAX);
        end
        return q[CHANNEL_BITS-1:0];
    endfunction

    // Add half the divisor, drop the power of two, multiply by the reciprocal.
    always_comb
    begin
        logic [NUM_BITS:0]    xq;
        logic [NUM_BITS:0]    xt;
        logic [MQ_BITS-1:0]   mq;
        logic [MQ_BITS-1:0]   mt;
        logic [MP_BITS-1:0]   mp;
        xq              = {prod.qn, 1'b0} + (NUM_BITS+1)'(DEN);
        xt              = {prod.tn, 1'b0} + (NUM_BITS+1)'(DEN);
        est_next.sector = prod.sector;
        est_next.val    = prod.val;
        est_next.yq     = xq[NUM_BITS -: YQ_BITS];
        est_next.yt     = xt[NUM_BITS -: YQ_BITS];
        est_next.yp     = prod.pn + YP_BITS'(CH_MAX >> 1);
        mq              = MQ_BITS'(est_next.yq) * MQ_BITS'(RQ);
        mt              = MQ_BITS'(est_next.yt) * MQ_BITS'(RQ);
        mp              = MP_BITS'(est_next.yp) * MP_BITS'(RP);
        est_next.qe     = mq[YQ_BITS +: QE_BITS];
        est_next.te     = mt[YQ_BITS +: QE_BITS];
        est_next.pe     = mp[YP_BITS +: QE_BITS];
    end

    // Correct the estimates and saturate.
    always_comb
    begin
        quot_next.sector = est_reg.sector;
        quot_next.val    = est_reg.val;
        quot_next.p      = fix_quot(YQ_BITS'(est_reg.yp), est_reg.pe, QT_BITS'(CH_MAX));
        quot_next.q      = fix_quot(est_reg.yq, est_reg.qe, QT_BITS'(QT_DIV));
        quot_next.t      = fix_quot(est_reg.yt, est_reg.te, QT_BITS'(QT_DIV));
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            est_reg <= est_next;
        end
        if (en.s5)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

[src/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB converter: stream handshake, sector select and output register.
//
//  Channel | Direction | Payload (lowest bit first)
//  --------+-----------+--------------------------------------------------
//  s_*     | in        | hue[14:0], saturation[7:0], brightness[7:0], pad
//  m_*     | out       | red[7:0], green[7:0], blue[7:0]
//
// One pixel enters per clock while s_tready is high.
// The depth is the decode stage, the two multiply stages, the two reciprocal divider stages and the output register.
// Each stage carries a valid bit and advances when it is empty or the next one advances,
// so bubbles close up and s_tready only falls when every stage holds a pixel.
// rst_n clears the valid bits asynchronously; the data registers are not reset.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // hue[14:0], saturation[22:15], brightness[30:23], zero pad
    input  logic [hsv2rgb_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsv2rgb_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import hsv2rgb_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    logic [HUE_BITS-1:0] hue;
    chan_t               saturation;
    chan_t               brightness;

    dec_t    dec;
    prod_t   prod;
    quot_t   quot;
    mul_en_t mul_en;
    div_en_t div_en;

    logic [3*CHANNEL_BITS-1:0] rgb_reg;
    logic [3*CHANNEL_BITS-1:0] rgb_next;

    // Input fields.
    assign hue        = s_tdata[HUE_BITS-1:0];
    assign saturation = s_tdata[HUE_BITS +: CHANNEL_BITS];
    assign brightness = s_tdata[HUE_BITS+CHANNEL_BITS +: CHANNEL_BITS];

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    // Valid bits follow their data.
    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready  = adv[0];
    assign mul_en.s2 = adv[1];
    assign mul_en.s3 = adv[2];
    assign div_en.s4 = adv[3];
    assign div_en.s5 = adv[4];

    hsv2rgb_hue_decode u_decode (
        .clk        (clk),
        .en         (adv[0]),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .dec        (dec)
    );

    hsv2rgb_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .dec  (dec),
        .prod (prod)
    );

    hsv2rgb_cdiv u_cdiv (
        .clk  (clk),
        .en   (div_en),
        .prod (prod),
        .quot (quot)
    );

    // Sector select; zero saturation needs no special case as p, q and t equal value.
    always_comb
    begin
        case (quot.sector)
            SEC_RED:    rgb_next = {quot.p, quot.t, quot.val};
            SEC_YELLOW: rgb_next = {quot.p, quot.val, quot.q};
            SEC_GREEN:  rgb_next = {quot.t, quot.val, quot.p};
            SEC_CYAN:   rgb_next = {quot.val, quot.q, quot.p};
            SEC_BLUE:   rgb_next = {quot.val, quot.p, quot.t};
            default:    rgb_next = {quot.q, quot.p, quot.val};
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES-1])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = M_TDATA_BITS'(rgb_reg);

    // The input only stalls when every stage holds a pixel.
    `H2R_ASSERT_NOW(a_stall_only_when_full, !s_tready, &vld_reg, "input stalled with a bubble in the pipeline")
    // A transaction on the input always fills the first stage.
    `H2R_ASSERT_NEXT(a_accept_fills_stage, s_tvalid && s_tready, vld_reg[0], "accepted pixel lost at the first stage")
    // p, q and t never exceed value.
    `H2R_ASSERT_NOW(a_quot_within_value, vld_reg[4], (quot.p <= quot.val) && (quot.q <= quot.val) && (quot.t <= quot.val), "divider result above value")

endmodule
